// ----- design/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/clr_pkg.sv -----
`default_nettype none

package clr_pkg;

  localparam int COORD_IN_W = 13;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_index_t;

endpackage

`default_nettype wire

// ----- design/clamped_line_rasterizer_unit.sv -----
// Clamped line rasterizer.
// Input channel (in_valid / in_stall): one word holds a line as two signed
// 13-bit endpoints. Each coordinate is clamped to the active image set by
// the cfg port (index 0 width, index 1 height, data 1..MAX_DIM; 0 acts as 1).
// Output channel (out_valid / out_stall): one word per pixel, drawn from the
// end with the smaller major coordinate; out_last_pixel marks the final one.
// A line of N pixels (N = max(|dx|,|dy|)+1, at most MAX_DIM) keeps the
// stepping busy after acceptance: a setup step picks the major axis and
// orders the ends, then one pixel per cycle while the output is not stalled
// comes from a residual adder and compares tracking the rounded minor
// coordinate. The clamp is done in the accepting cycle; the setup step then
// registers the ordered ends before the first pixel is stepped out.
// in_stall stays high from acceptance until the last pixel is loaded into
// the output register; the next line can be taken while that pixel waits.
// A stalled output holds its word and freezes the stepping.
// cfg_ready is always high; write registers only while the block is idle.
// Synchronous reset clears the sequencer and output valid and sets both
// image dimensions to 64.
`default_nettype none

`include "assert_macros.svh"

module clamped_line_rasterizer_unit
  import clr_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,

  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic signed [COORD_IN_W-1:0]  in_start_x,
  input  wire logic signed [COORD_IN_W-1:0]  in_start_y,
  input  wire logic signed [COORD_IN_W-1:0]  in_end_x,
  input  wire logic signed [COORD_IN_W-1:0]  in_end_y,

  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [$clog2(MAX_DIM)-1:0]    out_pixel_x,
  output      logic [$clog2(MAX_DIM)-1:0]    out_pixel_y,
  output      logic                          out_last_pixel,

  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data
);

  localparam int CW = $clog2(MAX_DIM);
  // residual spans [-2D, 4D) right after the add
  localparam int RW = CW + 3;
  localparam logic [COORD_IN_W-1:0] MAX_DIM_V = COORD_IN_W'(MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_t;

  state_t state_r, state_nxt;

  logic [CFG_DATA_W-1:0] img_w_r, img_w_nxt;
  logic [CFG_DATA_W-1:0] img_h_r, img_h_nxt;

  logic [CW-1:0] x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;

  logic [CW-1:0] maj_r, maj_nxt;
  logic [CW-1:0] maj_end_r, maj_end_nxt;
  logic [CW-1:0] min_r, min_nxt;
  logic          shallow_r, shallow_nxt;
  logic signed [RW-1:0] step_r, step_nxt;
  logic signed [RW-1:0] dbl_r, dbl_nxt;
  logic signed [RW-1:0] res_r, res_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic          out_last_r, out_last_nxt;

  logic [CFG_DATA_W-1:0] eff_w, eff_h;

  // setup terms
  logic signed [CW:0] dx, dy;
  logic [CW-1:0]      adx, ady;
  logic               shallow, swap;
  logic [CW-1:0]      s_maj, s_maj_end, s_min, s_min_end;
  logic signed [CW:0] s_dmin;
  logic [CW-1:0]      s_len;

  // stepping terms
  logic                 load;
  logic                 at_end;
  logic signed [RW-1:0] res_add;

  function automatic logic [CFG_DATA_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] raw);
    logic [CFG_DATA_W-1:0] d;
    d = raw;
    if (raw == '0) begin
      d = CFG_DATA_W'(1);
    end else if ({{(COORD_IN_W-CFG_DATA_W){1'b0}}, raw} > MAX_DIM_V) begin
      d = MAX_DIM_V[CFG_DATA_W-1:0];
    end
    return d;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input logic signed [COORD_IN_W-1:0] v,
                                                input logic [CFG_DATA_W-1:0] lim);
    logic signed [COORD_IN_W:0] lim_s;
    logic [CFG_DATA_W-1:0]      lim_m1;
    logic [CW-1:0]              c;
    lim_s  = signed'({{(COORD_IN_W+1-CFG_DATA_W){1'b0}}, lim});
    lim_m1 = lim - CFG_DATA_W'(1);
    if (v < 0) begin
      c = '0;
    end else if ({v[COORD_IN_W-1], v} >= lim_s) begin
      c = CW'(lim_m1);
    end else begin
      c = v[CW-1:0];
    end
    return c;
  endfunction

  assign eff_w = eff_dim(img_w_r);
  assign eff_h = eff_dim(img_h_r);

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign out_valid      = out_valid_r;
  assign out_pixel_x    = out_x_r;
  assign out_pixel_y    = out_y_r;
  assign out_last_pixel = out_last_r;

  // major axis selection and end ordering
  always_comb begin
    dx  = signed'({1'b0, x2_r}) - signed'({1'b0, x1_r});
    dy  = signed'({1'b0, y2_r}) - signed'({1'b0, y1_r});
    adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
    ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
    shallow = (ady <= adx);
    swap    = shallow ? (x1_r > x2_r) : (y1_r > y2_r);
    if (shallow) begin
      s_maj     = swap ? x2_r : x1_r;
      s_maj_end = swap ? x1_r : x2_r;
      s_min     = swap ? y2_r : y1_r;
      s_min_end = swap ? y1_r : y2_r;
    end else begin
      s_maj     = swap ? y2_r : y1_r;
      s_maj_end = swap ? y1_r : y2_r;
      s_min     = swap ? x2_r : x1_r;
      s_min_end = swap ? x1_r : x2_r;
    end
    s_dmin = signed'({1'b0, s_min_end}) - signed'({1'b0, s_min});
    s_len  = s_maj_end - s_maj;
  end

  // minor = start + floor((2*i*dmin + D) / 2D), tracked as residual in [0, 2D)
  assign load    = !out_valid_r || !out_stall;
  assign at_end  = (maj_r == maj_end_r);
  assign res_add = res_r + step_r;

  always_comb begin
    state_nxt     = state_r;
    img_w_nxt     = img_w_r;
    img_h_nxt     = img_h_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    maj_nxt       = maj_r;
    maj_end_nxt   = maj_end_r;
    min_nxt       = min_r;
    shallow_nxt   = shallow_r;
    step_nxt      = step_r;
    dbl_nxt       = dbl_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IMAGE_WIDTH:  img_w_nxt = cfg_data;
        CFG_IMAGE_HEIGHT: img_h_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x1_nxt    = clamp_coord(in_start_x, eff_w);
          y1_nxt    = clamp_coord(in_start_y, eff_h);
          x2_nxt    = clamp_coord(in_end_x, eff_w);
          y2_nxt    = clamp_coord(in_end_y, eff_h);
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        maj_nxt     = s_maj;
        maj_end_nxt = s_maj_end;
        min_nxt     = s_min;
        shallow_nxt = shallow;
        step_nxt    = RW'(s_dmin) <<< 1;
        dbl_nxt     = signed'(RW'({s_len, 1'b0}));
        res_nxt     = signed'(RW'(s_len));
        state_nxt   = ST_RUN;
      end
      ST_RUN: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = shallow_r ? maj_r : min_r;
          out_y_nxt     = shallow_r ? min_r : maj_r;
          out_last_nxt  = at_end;
          if (at_end) begin
            state_nxt = ST_IDLE;
          end else begin
            maj_nxt = maj_r + CW'(1);
            if (res_add >= dbl_r) begin
              res_nxt = res_add - dbl_r;
              min_nxt = min_r + CW'(1);
            end else if (res_add < 0) begin
              res_nxt = res_add + dbl_r;
              min_nxt = min_r - CW'(1);
            end else begin
              res_nxt = res_add;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      img_w_r     <= DIM_RESET;
      img_h_r     <= DIM_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      img_w_r     <= img_w_nxt;
      img_h_r     <= img_h_nxt;
    end
    x1_r       <= x1_nxt;
    y1_r       <= y1_nxt;
    x2_r       <= x2_nxt;
    y2_r       <= y2_nxt;
    maj_r      <= maj_nxt;
    maj_end_r  <= maj_end_nxt;
    min_r      <= min_nxt;
    shallow_r  <= shallow_nxt;
    step_r     <= step_nxt;
    dbl_r      <= dbl_nxt;
    res_r      <= res_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  `ASSERT_CLKD(a_res_range,
               (state_r == ST_RUN && !at_end) |-> (res_r >= 0 && res_r < dbl_r),
               "residual left [0, 2D)")
  `ASSERT_CLKD(a_maj_bound,
               (state_r == ST_RUN) |-> (maj_r <= maj_end_r),
               "major coordinate passed the line end")
  `ASSERT_CLKD(a_pix_inside,
               out_valid_r |-> ({1'b0, out_x_r} < {1'b0, eff_w} &&
                                {1'b0, out_y_r} < {1'b0, eff_h}),
               "pixel outside active image")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none

module tb
  import clr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM = 64;
  localparam int PIX_W = $clog2(MAX_DIM);
  localparam int IDLE_PCT = 24;

  typedef struct {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
    logic             last;
  } pixel_t;

  class line_scoreboard;
    pixel_t              pixel_q[$];
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int                  errors;
    int                  reports;

    function new();
      width_reg = DIM_RESET;
      height_reg = DIM_RESET;
      errors = 0;
      reports = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_IMAGE_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    function int eff(logic [CFG_DATA_W-1:0] r);
      if (r == 0) return 1;
      if (r > MAX_DIM) return MAX_DIM;
      return int'(r);
    endfunction

    function int clamp_coord(int v, int lim);
      if (v < 0) return 0;
      if (v >= lim) return lim - 1;
      return v;
    endfunction

    // floor(n/d + 1/2), exact
    function int round_half(int n, int d);
      int num;
      int den;
      int q;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      num = 2 * n + d;
      den = 2 * d;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
    endfunction

    function void push_pixel(int x, int y, bit last);
      pixel_t p;
      p.x = x[PIX_W-1:0];
      p.y = y[PIX_W-1:0];
      p.last = last;
      pixel_q.push_back(p);
    endfunction

    function void note_line(int sx, int sy, int ex, int ey);
      int w;
      int h;
      int x1;
      int y1;
      int x2;
      int y2;
      int dx;
      int dy;
      int t;
      int len;
      w = eff(width_reg);
      h = eff(height_reg);
      x1 = clamp_coord(sx, w);
      y1 = clamp_coord(sy, h);
      x2 = clamp_coord(ex, w);
      y2 = clamp_coord(ey, h);
      if (x1 == x2 && y1 == y2) begin
        push_pixel(x1, y1, 1'b1);
        return;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      if ((dy < 0 ? -dy : dy) <= (dx < 0 ? -dx : dx)) begin
        if (x1 > x2) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        len = dx + 1;
        for (int i = 0; i < len && i < MAX_DIM; i++)
          push_pixel(x1 + i, y1 + round_half(i * dy, dx), i == len - 1 || i == MAX_DIM - 1);
      end else begin
        if (y1 > y2) begin
          t = x1; x1 = x2; x2 = t;
          t = y1; y1 = y2; y2 = t;
        end
        dx = x2 - x1;
        dy = y2 - y1;
        len = dy + 1;
        for (int i = 0; i < len && i < MAX_DIM; i++)
          push_pixel(x1 + round_half(i * dx, dy), y1 + i, i == len - 1 || i == MAX_DIM - 1);
      end
    endfunction

    function void flag(string msg);
      errors++;
      if (reports < 10) begin
        reports++;
        $display("%0t: %s", $realtime, msg);
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, logic last);
      pixel_t p;
      if (pixel_q.size() == 0) begin
        flag($sformatf("unexpected pixel x=%0d y=%0d last=%0b", x, y, last));
        return;
      end
      p = pixel_q.pop_front();
      if (p.x !== x || p.y !== y || p.last !== last)
        flag($sformatf("pixel exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                       p.x, p.y, p.last, x, y, last));
    endfunction

    function void check_drained();
      if (pixel_q.size() != 0)
        flag($sformatf("%0d expected pixels never arrived", pixel_q.size()));
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [COORD_IN_W-1:0] in_start_x = '0;
  logic signed [COORD_IN_W-1:0] in_start_y = '0;
  logic signed [COORD_IN_W-1:0] in_end_x = '0;
  logic signed [COORD_IN_W-1:0] in_end_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [PIX_W-1:0]             out_pixel_x;
  logic [PIX_W-1:0]             out_pixel_y;
  logic                         out_last_pixel;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_INDEX_W-1:0]       cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  line_scoreboard sb;
  bit             calm = 1'b0;
  bit             held = 1'b0;
  int             hold_left = 0;
  int             pixels_taken = 0;

  clamped_line_rasterizer_unit #(.MAX_DIM(MAX_DIM)) u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_last_pixel (out_last_pixel),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls, plus one long hold-off so the output stalls the stepping
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) pixels_taken++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!held && pixels_taken >= 500) begin
      held = 1'b1;
      hold_left = 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel(out_pixel_x, out_pixel_y, out_last_pixel);
  end

  task automatic send_line(input int sx, input int sy, input int ex, input int ey);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_x <= sx[COORD_IN_W-1:0];
    in_start_y <= sy[COORD_IN_W-1:0];
    in_end_x <= ex[COORD_IN_W-1:0];
    in_end_y <= ey[COORD_IN_W-1:0];
    do @(posedge clk); while (in_stall);
    sb.note_line(sx, sy, ex, ey);
  endtask

  task automatic send_random_line();
    int w;
    int h;
    int sx;
    int sy;
    int ex;
    int ey;
    int pick;
    w = sb.eff(sb.width_reg);
    h = sb.eff(sb.height_reg);
    pick = $urandom_range(99);
    sx = $urandom_range(w + 7) - 4;
    sy = $urandom_range(h + 7) - 4;
    ex = $urandom_range(w + 7) - 4;
    ey = $urandom_range(h + 7) - 4;
    if (pick < 15) begin
      // full 13-bit range, mostly clamped
      sx = $urandom_range(8191) - 4096;
      sy = $urandom_range(8191) - 4096;
      ex = $urandom_range(8191) - 4096;
      ey = $urandom_range(8191) - 4096;
    end else if (pick < 22) begin
      ex = sx;
      ey = sy;
    end else if (pick < 30) begin
      ey = sy;
    end else if (pick < 38) begin
      ex = sx;
    end else if (pick < 46) begin
      ey = $urandom_range(1) ? sy + (ex - sx) : sy - (ex - sx);
    end
    send_line(sx, sy, ex, ey);
  endtask

  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_dims(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    wait_idle(4);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IMAGE_WIDTH;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_IMAGE_WIDTH, w);
    cfg_index <= CFG_IMAGE_HEIGHT;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(CFG_IMAGE_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("clamped_line_rasterizer_unit: mismatch");
    $finish;
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: points, clamped extremes, both axes, both directions, half-way rounding
    send_line(0, 0, 0, 0);
    send_line(-4096, -4096, 4095, 4095);
    send_line(4095, -4096, -4096, 4095);
    send_line(5, 10, 40, 10);
    send_line(40, 10, 5, 10);
    send_line(7, 3, 7, 50);
    send_line(7, 50, 7, 3);
    send_line(0, 0, 2, 1);
    send_line(2, 1, 0, 0);
    send_line(0, 1, 2, 0);
    send_line(3, 0, 4, 20);
    send_line(4, 20, 3, 0);
    send_line(10, 60, 13, 0);
    send_line(-1, -1, -1, -1);
    send_line(4095, 4095, 4095, 4095);
    send_line(100, 5, -100, 6);
    send_line(0, 63, 63, 0);
    send_line(-4096, 0, 4095, 0);
    send_line(0, -4096, 0, 4095);
    send_line(30, 30, 33, 31);
    send_line(20, 20, 21, 23);

    repeat (60) send_random_line();
    write_dims(7'd0, 7'd0);
    repeat (12) send_random_line();
    write_dims(7'd1, 7'd64);
    repeat (25) send_random_line();
    write_dims(7'd64, 7'd1);
    repeat (25) send_random_line();
    write_dims(7'd127, 7'd127);
    calm = 1'b1;
    repeat (40) send_random_line();
    calm = 1'b0;
    write_dims(7'd2, 7'd3);
    repeat (25) send_random_line();
    write_dims(7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
    repeat (40) send_random_line();
    write_dims(7'd127, 7'd0);
    repeat (12) send_random_line();
    write_dims(7'd33, 7'd64);
    repeat (25) send_random_line();

    wait_idle(80);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("clamped_line_rasterizer_unit: match");
    end else begin
      $display("clamped_line_rasterizer_unit: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
